### rtl/core/rfeht_pkg.sv
// shared types and constants for the rf energy history tracker
// no dependencies, imported by every module of the block
package rfeht_pkg;

    localparam int HISTORY_DEPTH_DEF   = 120;
    localparam int CHANNEL_COUNT       = 128;
    localparam int SAMPLES_PER_MEASURE = 5;

    localparam int DET_W   = 5;
    localparam int AGE_W   = 7;
    localparam int VAL_W   = 4;
    localparam int CHAN_W  = 7;
    localparam int WPOS_W  = 7;
    localparam int OPC_W   = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    localparam logic [VAL_W-1:0] CAP_RESET = 4'd10;

    localparam logic [OPC_W-1:0] OPC_MEASURE = 2'd0;
    localparam logic [OPC_W-1:0] OPC_CH_UP   = 2'd1;
    localparam logic [OPC_W-1:0] OPC_CH_DOWN = 2'd2;
    localparam logic [OPC_W-1:0] OPC_READ    = 2'd3;

    typedef enum logic [1:0] {
        UOP_MIN    = 2'd0,
        UOP_MAX    = 2'd1,
        UOP_ADDMOD = 2'd2
    } uop_t;

endpackage

### rtl/core/rfeht_alu.sv
// shared compare / add unit: min, max and add modulo history depth
// depends on rfeht_pkg
module rfeht_alu
    import rfeht_pkg::*;
#(
    parameter int W             = 8,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  uop_t         mode,
    output logic [W-1:0] result,
    output logic         gt
);

    logic [W:0] sum;
    logic [W:0] wrapped;

    assign gt      = a > b;
    assign sum     = {1'b0, a} + {1'b0, b};
    assign wrapped = sum - (W+1)'(HISTORY_DEPTH);

    always_comb begin
        unique case (mode)
            UOP_MIN:    result = gt ? b : a;
            UOP_MAX:    result = gt ? a : b;
            UOP_ADDMOD: result = (sum >= (W+1)'(HISTORY_DEPTH)) ? wrapped[W-1:0] : sum[W-1:0];
            default:    result = a;
        endcase
    end

endmodule

### rtl/core/rf_energy_history_tracker.sv
// rf energy history tracker top level: sequencer, history memory, output register
// depends on rfeht_pkg and rfeht_alu
//
// channel   | port group             | contents (lowest bit first)
// ----------+------------------------+------------------------------------------------
// input     | s_tvalid/tready/tdata  | tdata: detector_bits[4:0], age[11:5]; tuser: opcode
// result    | m_tvalid/tready/tdata  | strength[3:0], peak[7:4], channel[14:8], wpos[21:15]
// config    | cfg_wen/cfg_wdata      | strength_cap
//
// one word at a time, from accept through DECODE, then WRITE (measure) or RADDR, RDATA (read), to DONE
// a measure that writes slot zero without raising the peak walks the history through
// the shared compare unit in ST_SWEEP and ST_DRAIN, one memory read per cycle
// reset and channel changes clear the history valid bits at once, no clearing pass
// s_tready is low while a word is in work or its result cannot enter the output register
module rf_energy_history_tracker
    import rfeht_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // detector_bits, age
    input  logic [OPC_W-1:0]    s_tuser,   // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // strength, peak, channel, write_position
    input  logic                cfg_wen,
    input  logic [VAL_W-1:0]    cfg_wdata
);

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int UW = (AW > AGE_W) ? AW : AGE_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_WRITE  = 8'b0000_0100,
        ST_SWEEP  = 8'b0000_1000,
        ST_DRAIN  = 8'b0001_0000,
        ST_RADDR  = 8'b0010_0000,
        ST_RDATA  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [OPC_W-1:0]    opcode_reg, opcode_next;
    logic [DET_W-1:0]    bits_reg, bits_next;
    logic [AGE_W-1:0]    age_reg, age_next;
    logic [VAL_W-1:0]    cap_reg, cap_next;
    logic [VAL_W-1:0]    value_reg, value_next;
    logic [VAL_W-1:0]    peak_reg, peak_next;
    logic [VAL_W-1:0]    acc_reg, acc_next;
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [AW-1:0]       slot_reg, slot_next;
    logic [AW-1:0]       asat_reg, asat_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic                dv_reg, dv_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [VAL_W-1:0]         mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [VAL_W-1:0]         rd_data_reg;
    logic [AW-1:0]            rd_addr;
    logic                     mem_we;
    logic                     hist_clear;

    logic [2:0]       hits;
    logic [VAL_W-1:0] hits2;
    logic [AW-1:0]    slot_adv;

    logic [UW-1:0] u_a, u_b, u_res;
    uop_t          u_mode;
    logic          u_gt;

    rfeht_alu #(
        .W             (UW),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_alu (
        .a      (u_a),
        .b      (u_b),
        .mode   (u_mode),
        .result (u_res),
        .gt     (u_gt)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        hits = '0;
        for (int i = 0; i < DET_W; i++) begin
            if (i < SAMPLES_PER_MEASURE) begin
                hits = hits + 3'(bits_reg[i]);
            end
        end
        hits2 = {hits, 1'b0};
    end

    assign slot_adv = (slot_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;

    // shared unit operand selection
    always_comb begin
        u_a    = '0;
        u_b    = '0;
        u_mode = UOP_MIN;
        unique case (state_reg)
            ST_DECODE: begin
                if (opcode_reg == OPC_MEASURE) begin
                    u_a = UW'(hits2);
                    u_b = UW'(cap_reg);
                end else begin
                    u_a = UW'(age_reg);
                    u_b = UW'(HISTORY_DEPTH - 1);
                end
            end
            ST_WRITE: begin
                u_a    = UW'(value_reg);
                u_b    = UW'(peak_reg);
                u_mode = UOP_MAX;
            end
            ST_SWEEP, ST_DRAIN: begin
                u_a    = UW'(acc_reg);
                u_b    = UW'(rd_data_reg);
                u_mode = UOP_MAX;
            end
            ST_RADDR: begin
                u_a    = UW'(slot_reg);
                u_b    = UW'(asat_reg);
                u_mode = UOP_ADDMOD;
            end
            default: begin
                u_mode = UOP_MIN;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        opcode_next   = opcode_reg;
        bits_next     = bits_reg;
        age_next      = age_reg;
        cap_next      = cfg_wen ? cfg_wdata : cap_reg;
        value_next    = value_reg;
        peak_next     = peak_reg;
        acc_next      = acc_reg;
        chan_next     = chan_reg;
        slot_next     = slot_reg;
        asat_next     = asat_reg;
        cnt_next      = cnt_reg;
        dv_next       = dv_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_addr       = slot_reg;
        mem_we        = 1'b0;
        hist_clear    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    opcode_next = s_tuser;
                    bits_next   = s_tdata[DET_W-1:0];
                    age_next    = s_tdata[DET_W+AGE_W-1:DET_W];
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (opcode_reg)
                    OPC_MEASURE: begin
                        value_next = VAL_W'(u_res);
                        state_next = ST_WRITE;
                    end
                    OPC_READ: begin
                        asat_next  = AW'(u_res);
                        state_next = ST_RADDR;
                    end
                    OPC_CH_UP: begin
                        chan_next  = (chan_reg < CHAN_W'(CHANNEL_COUNT - 1)) ?
                                     chan_reg + 1'b1 : '0;
                        hist_clear = 1'b1;
                        peak_next  = '0;
                        slot_next  = '0;
                        value_next = '0;
                        state_next = ST_DONE;
                    end
                    OPC_CH_DOWN: begin
                        chan_next  = (chan_reg != '0) ?
                                     chan_reg - 1'b1 : CHAN_W'(CHANNEL_COUNT - 1);
                        hist_clear = 1'b1;
                        peak_next  = '0;
                        slot_next  = '0;
                        value_next = '0;
                        state_next = ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_WRITE: begin
                mem_we = 1'b1;
                if (u_gt) begin
                    peak_next  = value_reg;
                    slot_next  = slot_adv;
                    state_next = ST_DONE;
                end else if (slot_reg == '0) begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    dv_next    = 1'b0;
                    state_next = ST_SWEEP;
                end else begin
                    slot_next  = slot_adv;
                    state_next = ST_DONE;
                end
            end
            ST_SWEEP: begin
                rd_addr = cnt_reg;
                if (dv_reg) begin
                    acc_next = VAL_W'(u_res);
                end
                dv_next = 1'b1;
                if (cnt_reg == AW'(HISTORY_DEPTH - 1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                peak_next  = VAL_W'(u_res);
                slot_next  = slot_adv;
                state_next = ST_DONE;
            end
            ST_RADDR: begin
                rd_addr    = AW'(u_res);
                state_next = ST_RDATA;
            end
            ST_RDATA: begin
                value_next = rd_data_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, WPOS_W'(slot_reg), chan_reg, peak_reg, value_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= CAP_RESET;
            peak_reg     <= '0;
            chan_reg     <= '0;
            slot_reg     <= '0;
            dv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            peak_reg     <= peak_next;
            chan_reg     <= chan_next;
            slot_reg     <= slot_next;
            dv_reg       <= dv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        opcode_reg  <= opcode_next;
        bits_reg    <= bits_next;
        age_reg     <= age_next;
        value_reg   <= value_next;
        acc_reg     <= acc_next;
        asat_reg    <= asat_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

    // history memory, entries without a valid bit read as zero
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[slot_reg] <= value_reg;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || hist_clear) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[slot_reg] <= 1'b1;
        end
    end

endmodule

### rtl/core/rfeht_checker.sv
// port-level checks for the rf energy history tracker, bound to the top level
// depends on rfeht_pkg and rf_energy_history_tracker
module rfeht_checker
    import rfeht_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    // the strength in every result word is bounded by the running peak
    a_strength_le_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] <= m_tdata[7:4]))
        else $error("strength above peak");

    a_wpos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((HISTORY_DEPTH > 128) || (m_tdata[21:15] < HISTORY_DEPTH)))
        else $error("write position beyond history depth");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind rf_energy_history_tracker rfeht_checker #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
) u_rfeht_checker (.*);

### tb/tb_top.sv
// self-checking testbench for rf_energy_history_tracker: directed and random stimulus, a built-in
// predictor of the history ring, peak and channel, and a checker on every result word
// depends on rfeht_pkg and the rtl of the block
module tb_top;
    import rfeht_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH     = HISTORY_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 250;
    localparam int PHASE_CMDS     = 200;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [DET_W-1:0] detector;
        logic [AGE_W-1:0] age;
    } energy_cmd_t;

    typedef struct packed {
        logic [VAL_W-1:0]  strength;
        logic [VAL_W-1:0]  peak;
        logic [CHAN_W-1:0] channel;
        logic [WPOS_W-1:0] wpos;
    } energy_report_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic [OPC_W-1:0]    s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_wen   = 1'b0;
    logic [VAL_W-1:0]    cfg_wdata = '0;

    energy_cmd_t    cmd_backlog[$];
    energy_report_t pending_reports[$];
    energy_cmd_t    cmd_on_bus;

    logic [VAL_W-1:0] hist_model[HIST_DEPTH];
    int               wslot_model;
    logic [VAL_W-1:0] peak_model;
    int               chan_model;
    logic [VAL_W-1:0] cap_model;

    int  tx_gap;
    int  rx_stall;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    int  hold_req   = 0;
    int  hold_seen  = 0;
    int  err_count  = 0;
    int  cmds_sent  = 0;
    int  reports_checked = 0;
    int  recomputes = 0;
    int  peak_drops = 0;
    int  chan_wraps = 0;

    rf_energy_history_tracker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void clear_history_model();
        foreach (hist_model[i]) hist_model[i] = '0;
        peak_model  = '0;
        wslot_model = 0;
    endfunction

    function automatic energy_report_t track_energy(energy_cmd_t cmd);
        energy_report_t rep;
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] old_peak;
        int hits;
        int pos;
        val = '0;
        case (cmd.opcode)
            OPC_MEASURE: begin
                hits = 2 * $countones(cmd.detector);
                if (hits > int'(cap_model)) hits = int'(cap_model);
                val = hits[VAL_W-1:0];
                hist_model[wslot_model] = val;
                if (val > peak_model) begin
                    peak_model = val;
                end else if (wslot_model == 0) begin
                    old_peak   = peak_model;
                    peak_model = '0;
                    foreach (hist_model[i])
                        if (hist_model[i] > peak_model) peak_model = hist_model[i];
                    recomputes++;
                    if (peak_model < old_peak) peak_drops++;
                end
                wslot_model = (wslot_model + 1) % HIST_DEPTH;
            end
            OPC_CH_UP: begin
                if (chan_model == CHANNEL_COUNT - 1) begin
                    chan_model = 0;
                    chan_wraps++;
                end else begin
                    chan_model++;
                end
                clear_history_model();
            end
            OPC_CH_DOWN: begin
                if (chan_model == 0) begin
                    chan_model = CHANNEL_COUNT - 1;
                    chan_wraps++;
                end else begin
                    chan_model--;
                end
                clear_history_model();
            end
            default: begin
                pos = (cmd.age > HIST_DEPTH - 1) ? HIST_DEPTH - 1 : int'(cmd.age);
                val = hist_model[(wslot_model + pos) % HIST_DEPTH];
            end
        endcase
        rep.strength = val;
        rep.peak     = peak_model;
        rep.channel  = chan_model[CHAN_W-1:0];
        rep.wpos     = wslot_model[WPOS_W-1:0];
        return rep;
    endfunction

    // sender: one word on the bus at a time, random gap after each accepted word while tx_idle_on
    always @(posedge aclk) begin : cmd_driver
        energy_cmd_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_reports.push_back(track_energy(cmd_on_bus));
                cmds_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    nxt        = cmd_backlog.pop_front();
                    cmd_on_bus = nxt;
                    s_tvalid  <= 1'b1;
                    s_tuser   <= nxt.opcode;
                    s_tdata   <= {{(S_DATA_W-DET_W-AGE_W){1'b0}}, nxt.age, nxt.detector};
                    tx_gap     = tx_idle_on ? $urandom_range(0, 3) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: report %0d %s mismatch, expected %0d, actual %0d",
                     $time, reports_checked, name, want, got);
            err_count++;
        end
    endtask

    // receiver: random stall after each word while rx_idle_on, long hold on request
    always @(posedge aclk) begin : report_monitor
        energy_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, m_tdata);
                    err_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("strength", int'(want.strength), int'(m_tdata[3:0]));
                    check_field("peak", int'(want.peak), int'(m_tdata[7:4]));
                    check_field("channel", int'(want.channel), int'(m_tdata[14:8]));
                    check_field("write_position", int'(want.wpos), int'(m_tdata[21:15]));
                end
                reports_checked++;
                rx_stall = rx_idle_on ? $urandom_range(0, 3) : 0;
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                rx_stall  = LONG_HOLD;
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic queue_cmd(logic [OPC_W-1:0] op, logic [DET_W-1:0] det,
                             logic [AGE_W-1:0] age);
        energy_cmd_t c;
        c.opcode   = op;
        c.detector = det;
        c.age      = age;
        cmd_backlog.push_back(c);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (cmd_backlog.size() != 0 || s_tvalid || pending_reports.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cap(logic [VAL_W-1:0] cap);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= cap;
        cap_model  = cap;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        @(negedge aclk);
    endtask

    // channel change, then a run of measures, reads and rare channel changes; strong detector hits early,
    // weak ones later so that the peak can fall at a wrap recompute
    task automatic queue_segment(output int n);
        int len;
        int switch_at;
        logic [DET_W-1:0] lo_mask;
        logic [DET_W-1:0] det;
        logic [OPC_W-1:0] op;
        len       = $urandom_range(10, 320);
        switch_at = $urandom_range(0, len / 3);
        lo_mask   = ($urandom_range(0, 3) == 0) ? '0 : DET_W'(1) << $urandom_range(0, 4);
        queue_cmd($urandom_range(0, 1) ? OPC_CH_UP : OPC_CH_DOWN, DET_W'($urandom),
                  AGE_W'($urandom));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 2)
                op = $urandom_range(0, 1) ? OPC_CH_UP : OPC_CH_DOWN;
            else if ($urandom_range(0, 9) < 7)
                op = OPC_MEASURE;
            else
                op = OPC_READ;
            det = DET_W'($urandom);
            if (i >= switch_at) det = det & lo_mask;
            queue_cmd(op, det, AGE_W'($urandom_range(0, 127)));
        end
        n = len + 1;
    endtask

    initial begin : stimulus
        int n;
        int total;
        logic [VAL_W-1:0] cap;
        chan_model = 0;
        cap_model  = CAP_RESET;
        clear_history_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, every opcode, age saturation, channel wraps
        queue_cmd(OPC_READ, 5'h1F, 7'd0);
        queue_cmd(OPC_MEASURE, 5'h00, 7'd127);
        queue_cmd(OPC_MEASURE, 5'h1F, 7'd0);
        queue_cmd(OPC_MEASURE, 5'h01, 7'd0);
        queue_cmd(OPC_MEASURE, 5'h10, 7'd0);
        queue_cmd(OPC_MEASURE, 5'h0A, 7'd0);
        queue_cmd(OPC_MEASURE, 5'h15, 7'd0);
        queue_cmd(OPC_READ, 5'h00, 7'd0);
        queue_cmd(OPC_READ, 5'h00, 7'd1);
        queue_cmd(OPC_READ, 5'h00, 7'd119);
        queue_cmd(OPC_READ, 5'h00, 7'd120);
        queue_cmd(OPC_READ, 5'h1F, 7'd127);
        queue_cmd(OPC_READ, 5'h00, 7'd64);
        queue_cmd(OPC_CH_DOWN, 5'h1F, 7'd127);
        queue_cmd(OPC_READ, 5'h00, 7'd119);
        queue_cmd(OPC_CH_UP, 5'h00, 7'd0);
        queue_cmd(OPC_CH_UP, 5'h1F, 7'd127);
        queue_cmd(OPC_MEASURE, 5'h03, 7'd0);
        queue_cmd(OPC_CH_DOWN, 5'h00, 7'd0);
        queue_cmd(OPC_MEASURE, 5'h00, 7'd0);
        queue_cmd(OPC_MEASURE, 5'h07, 7'd0);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: cap = 4'd15;
                1: cap = 4'd0;
                2: cap = 4'd1;
                4: cap = 4'd15;
                default: cap = VAL_W'($urandom_range(2, 14));
            endcase
            write_cap(cap);
            tx_idle_on = (phase != 4);
            rx_idle_on = (phase != 4);
            if (phase == 2) hold_req++;
            total = 0;
            while (total < PHASE_CMDS) begin
                queue_segment(n);
                total += n;
            end
            wait_drained();
        end
        write_cap(CAP_RESET);
        queue_cmd(OPC_MEASURE, 5'h1F, 7'd0);
        queue_cmd(OPC_READ, 5'h00, 7'd119);
        wait_drained();

        repeat (20) @(posedge aclk);
        $display("summary: %0d words sent, %0d results checked, caps 0 to 15", cmds_sent,
                 reports_checked);
        $display("summary: %0d wrap recomputes, %0d peak drops, %0d channel wraps",
                 recomputes, peak_drops, chan_wraps);
        if (err_count == 0 && pending_reports.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d results outstanding", err_count,
                     pending_reports.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/rfeht_pkg.sv
rtl/core/rfeht_alu.sv
rtl/core/rf_energy_history_tracker.sv
rtl/core/rfeht_checker.sv
tb/tb_top.sv
